// ===== design/kmet_pkg.sv =====
// Package: key matrix sizes, level codes, controller states and control structs.
package kmet_pkg;

    localparam int ROWS     = 5;
    localparam int COLS     = 5;
    localparam int MAX_KEYS = 25;
    localparam int NKEYS    = (ROWS * COLS > MAX_KEYS) ? MAX_KEYS : ROWS * COLS;
    localparam int SCAN_W   = 25;
    localparam int KEY_W    = 5;
    localparam int LEVEL_W  = 2;

    // Bits of the scan word that belong to real keys.
    localparam logic [SCAN_W-1:0] KEY_MASK =
        (NKEYS >= SCAN_W) ? {SCAN_W{1'b1}} : SCAN_W'((64'd1 << NKEYS) - 64'd1);

    localparam logic [KEY_W-1:0] TOP_KEY = KEY_W'(NKEYS - 1);

    typedef enum logic [LEVEL_W-1:0] {
        LVL_LOW  = 2'd0,
        LVL_RISE = 2'd1,
        LVL_HIGH = 2'd2,
        LVL_FALL = 2'd3
    } t_level;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic load;   // take a new frame, update all levels, clear walk position
        logic step;   // look at the key under the walk position
    } t_ctrl_cmd;

    typedef struct packed {
        logic at_last;   // walk position is on the last key
        logic out_free;  // output register can take an item this cycle
    } t_dp_status;

    // Level of one key after a new scan bit.
    function automatic t_level next_level(input logic nb, input logic pb, input t_level lvl);
        t_level nl;
        nl = lvl;
        if (nb != pb) begin
            nl = nb ? LVL_RISE : LVL_FALL;
        end else if (lvl == LVL_RISE) begin
            nl = LVL_HIGH;
        end else if (lvl == LVL_FALL) begin
            nl = LVL_LOW;
        end
        return nl;
    endfunction

endpackage

// ===== design/kmet_scan_if.sv =====
// Interface: scan frame channel.
interface kmet_scan_if;
    logic                           valid;
    logic                           ready;
    logic [kmet_pkg::SCAN_W-1:0]    scan_bits;

    modport source (output valid, output scan_bits, input ready);
    modport sink   (input valid, input scan_bits, output ready);
endinterface

// ===== design/kmet_event_if.sv =====
// Interface: key event channel.
interface kmet_event_if;
    logic                           valid;
    logic                           ready;
    logic [kmet_pkg::KEY_W-1:0]     key_index;
    logic [kmet_pkg::LEVEL_W-1:0]   new_level;
    logic                           frame_end;

    modport source (output valid, output key_index, output new_level, output frame_end,
                    input ready);
    modport sink   (input valid, input key_index, input new_level, input frame_end,
                    output ready);
endinterface

// ===== design/kmet_ctrl.sv =====
// Controller: frame accept and key walk sequencing.
module kmet_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_scan_valid,
    output logic                   o_scan_ready,
    input  kmet_pkg::t_dp_status   i_status,
    output kmet_pkg::t_ctrl_cmd    o_cmd
);

    kmet_pkg::t_state r_state;
    kmet_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmet_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_scan_ready = 1'b0;
        o_cmd        = '0;
        case (r_state)
            kmet_pkg::ST_IDLE: begin
                o_scan_ready = 1'b1;
                if (i_scan_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = kmet_pkg::ST_WALK;
                end
            end
            kmet_pkg::ST_WALK: begin
                // advance only when a found event has somewhere to go
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.at_last) begin
                        n_state = kmet_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = kmet_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/kmet_datapath.sv =====
// Datapath: previous frame, key levels, change mask, walk counter and output register.
module kmet_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kmet_pkg::t_ctrl_cmd              i_cmd,
    input  logic [kmet_pkg::SCAN_W-1:0]      i_scan_bits,
    input  logic                             i_out_ready,
    output kmet_pkg::t_dp_status             o_status,
    output logic                             o_out_valid,
    output logic [kmet_pkg::KEY_W-1:0]       o_key_index,
    output logic [kmet_pkg::LEVEL_W-1:0]     o_new_level,
    output logic                             o_frame_end
);

    logic [kmet_pkg::SCAN_W-1:0]   r_prev;
    logic [kmet_pkg::SCAN_W-1:0]   r_mask;
    kmet_pkg::t_level              r_levels [kmet_pkg::MAX_KEYS];
    logic [kmet_pkg::KEY_W-1:0]    r_pos;
    logic                          r_out_valid;
    logic [kmet_pkg::KEY_W-1:0]    r_key;
    logic [kmet_pkg::LEVEL_W-1:0]  r_lvl;
    logic                          r_end;

    logic [kmet_pkg::SCAN_W-1:0]   scan;
    kmet_pkg::t_level              n_levels [kmet_pkg::MAX_KEYS];
    logic [kmet_pkg::SCAN_W-1:0]   n_mask;
    logic [kmet_pkg::SCAN_W-1:0]   pos_bit;
    logic [kmet_pkg::SCAN_W-1:0]   rest_mask;
    logic                          hit;

    assign scan = i_scan_bits & kmet_pkg::KEY_MASK;

    // every key settles independently of the others
    always_comb begin
        n_mask = '0;
        for (int k = 0; k < kmet_pkg::MAX_KEYS; k++) begin
            n_levels[k] = kmet_pkg::next_level(scan[k], r_prev[k], r_levels[k]);
            n_mask[k]   = (n_levels[k] != r_levels[k]);
        end
    end

    assign pos_bit   = kmet_pkg::SCAN_W'(1) << r_pos;
    assign hit       = |(r_mask & pos_bit);
    assign rest_mask = r_mask & ~pos_bit;

    assign o_status.at_last  = (r_pos == kmet_pkg::TOP_KEY);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_mask <= '0;
            r_pos  <= '0;
            for (int k = 0; k < kmet_pkg::MAX_KEYS; k++) begin
                r_levels[k] <= kmet_pkg::LVL_LOW;
            end
        end else if (i_cmd.load) begin
            r_prev   <= scan;
            r_mask   <= n_mask;
            r_pos    <= '0;
            r_levels <= n_levels;
        end else if (i_cmd.step) begin
            r_mask <= rest_mask;
            r_pos  <= o_status.at_last ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && hit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && hit) begin
            r_key <= r_pos;
            r_lvl <= r_levels[r_pos];
            r_end <= (rest_mask == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_index = r_key;
    assign o_new_level = r_lvl;
    assign o_frame_end = r_end;

endmodule

// ===== design/key_matrix_edge_tracker.sv =====
// Top level: key matrix edge and level tracker.
// Input channel i_scan carries one full matrix scan per item, one bit per key,
// key = row*COLS + col, 1 = pressed. Bits at or above ROWS*COLS are ignored.
// Output channel o_event carries one item per key whose level changed:
// key_index, new_level (0 low, 1 rising, 2 high, 3 falling) and frame_end,
// which is set on the last item of a frame. A frame with no change emits nothing.
// Timing: taking a frame also updates every key's level and builds a mask of
// changed keys. A counter then walks the keys, one per cycle while the output
// register can take an item; the earliest event is made by the first walk step
// after the accept and is registered in the output register.
// Events go out in ascending key order through one output register. When the
// receiver stalls, the walk holds on its current key while that register is
// full. The next frame is taken as soon as the walk ends,
// even while the last event of the previous frame still waits.
// Reset (synchronous, active low) clears the previous frame to zeros, all key
// levels to low, the walk counter and the output valid.
module key_matrix_edge_tracker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kmet_scan_if.sink     i_scan,
    kmet_event_if.source  o_event
);

    kmet_pkg::t_ctrl_cmd   cmd;
    kmet_pkg::t_dp_status  status;

    kmet_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scan_valid (i_scan.valid),
        .o_scan_ready (i_scan.ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    kmet_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_scan_bits (i_scan.scan_bits),
        .i_out_ready (o_event.ready),
        .o_status    (status),
        .o_out_valid (o_event.valid),
        .o_key_index (o_event.key_index),
        .o_new_level (o_event.new_level),
        .o_frame_end (o_event.frame_end)
    );

endmodule
